>>> rtl/edm_pkg.sv
// shared widths, operation codes, configuration register indexes and divider request/response types
package edm_pkg;

  localparam int MAX_DIM   = 64;
  localparam int DIM_AW    = 6;
  localparam int DIM_CW    = 7;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int M2_W      = 48;
  localparam int DIV_W     = 64 + FRAC_BITS;
  localparam int DIV_SW    = 7;
  localparam int LOG_W     = 21;
  localparam int SUM_W     = 50;
  localparam int CAP_W     = 41;
  localparam int IN_W      = 72;
  localparam int OUT_W     = 200;

  // operation codes carried on in_tuser
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // configuration register indexes
  localparam logic CFG_DIM = 1'b0;
  localparam logic CFG_KL  = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_SW-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> rtl/embedding_drift_monitor_unit.sv
// embedding drift monitor: per-dimension running mean/M2 and drift measures
//
//  channel | direction | handshake               | payload
//  in_     | slave     | in_tvalid / in_tready   | tuser op, tdata index/value/var, tlast
//  out_    | master    | out_tvalid / out_tready | tdata statistics item, tlast final
//  cfg_    | slave     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// sample element: memory read, 32-step divide, multiply, write back
// load and clear: done on acceptance, the state stays idle
// query with baseline and more than 10 vectors: per dimension its time is set
// by the shared one-bit-per-cycle divider plus the square root and log steps
// reset: running statistics read as zero through per-entry valid bits, no sweep
// a waiting result blocks only the query that needs the output register
module embedding_drift_monitor_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // index[5:0], value[37:6], base_variance[69:38], zero fill
  input  logic [edm_pkg::IN_W-1:0]   in_tdata,
  // op[1:0]
  input  logic [1:0]                 in_tuser,
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // dim_index[5:0], mean[37:6], variance[69:38], sample_count[101:70],
  // kl_divergence[133:102], frobenius_shift[165:134], mean_shift[197:166],
  // alert[198], zero fill
  output logic [edm_pkg::OUT_W-1:0]  out_tdata,
  output logic                       out_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [edm_pkg::DATA_W-1:0] cfg_data
);
  import edm_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SRD   = 5'd1;
  localparam logic [4:0] S_SDIV  = 5'd2;
  localparam logic [4:0] S_SMUL  = 5'd3;
  localparam logic [4:0] S_QRD   = 5'd4;
  localparam logic [4:0] S_QVAR  = 5'd5;
  localparam logic [4:0] S_QVDIV = 5'd6;
  localparam logic [4:0] S_QPRE  = 5'd7;
  localparam logic [4:0] S_QRAT  = 5'd8;
  localparam logic [4:0] S_QSQ   = 5'd9;
  localparam logic [4:0] S_QSQRT = 5'd10;
  localparam logic [4:0] S_LOGI  = 5'd11;
  localparam logic [4:0] S_LOGS  = 5'd12;
  localparam logic [4:0] S_QLN   = 5'd13;
  localparam logic [4:0] S_QFD   = 5'd14;
  localparam logic [4:0] S_FSQRT = 5'd15;
  localparam logic [4:0] S_QEMIT = 5'd16;

  localparam logic [DATA_W-1:0] LN2_Q30 = 32'd744261118;
  localparam logic [CAP_W-1:0]  TERM_CAP = CAP_W'(1) << (CAP_W - 1);
  localparam logic [63:0]       SQ_TOP = 64'(1) << 62;
  localparam logic [SUM_W-1:0]  ONE_Q = SUM_W'(1) << FRAC_BITS;

  function automatic logic [4:0] lead_one(input logic [DATA_W-1:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  // state and configuration
  logic [4:0]        state_r, state_nxt;
  logic [DIM_CW-1:0] dim_in_use_r;
  logic [DATA_W-1:0] kl_limit_r;
  logic [DATA_W-1:0] vc_r;
  logic              base_valid_r;
  logic [MAX_DIM-1:0] run_vld_r;
  logic              run_vld_q;

  // memories
  logic [M2_W+DATA_W-1:0] run_mem [MAX_DIM];
  logic [2*DATA_W-1:0]    base_mem [MAX_DIM];
  logic [M2_W+DATA_W-1:0] run_q;
  logic [2*DATA_W-1:0]    base_q;

  // item registers
  logic [DATA_W-1:0] x_r;
  logic [DIM_AW-1:0] idx_r;
  logic              last_r;
  logic [DIM_AW-1:0] d_r;
  logic              en_r;
  logic [DATA_W-1:0] dmag_r;
  logic              dneg_r;
  logic [DATA_W-1:0] nm_r;
  logic [DATA_W-1:0] var_r;
  logic [63:0]       d2_r;
  logic [CAP_W-1:0]  ratio_r;
  logic [CAP_W-1:0]  sqt_r;
  logic [DATA_W-1:0] lm_r;
  logic [LOG_W-1:0]  lr_r;
  logic [LOG_W-1:0]  l0_r;
  logic [3:0]        lk_r;
  logic              lsel_r;
  logic [LOG_W+1:0]  ln_r;
  logic [SUM_W-1:0]  ksum_r;
  logic [63:0]       fsum_r;
  logic [DATA_W-1:0] mshift_r;
  logic [DATA_W-1:0] frob_r;
  logic [63:0]       sqx_r;
  logic [63:0]       sqres_r;
  logic [63:0]       sqbit_r;
  logic              out_tvalid_r;
  logic [OUT_W-1:0]  out_tdata_r;
  logic              out_tlast_r;

  // combinational
  logic [1:0]        in_op;
  logic [DIM_AW-1:0] in_idx;
  logic [DATA_W-1:0] in_val;
  logic [DATA_W-1:0] in_bvar;
  logic              accept;
  logic [DIM_CW-1:0] dim;
  logic              idx_ok;
  logic              last_dim;
  logic              slot_free;
  logic [DIM_AW-1:0] mem_ra;
  logic              run_re, run_we, base_re, base_we;
  logic [DATA_W-1:0] rm, bm, bv, v0, v1;
  logic [M2_W-1:0]   m2;
  logic [DATA_W-1:0] vc_n;
  logic [DATA_W:0]   s_delta, s_delta_n;
  logic [DATA_W-1:0] s_dmag;
  logic [DATA_W-1:0] q32, nm_c;
  logic [DATA_W:0]   e_diff, e_diff_n;
  logic [DATA_W-1:0] emag;
  logic [M2_W:0]     m2_sum;
  logic [M2_W-1:0]   m2_new;
  logic [DATA_W:0]   dm_diff, dm_diff_n;
  logic [DATA_W-1:0] dm;
  logic [DATA_W:0]   fd_diff, fd_diff_n;
  logic [DATA_W-1:0] fd;
  logic [DATA_W-1:0] mul_a, mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       sq_t, sqx_new, sqres_new;
  logic              sq_ge;
  logic [DATA_W-1:0] log_x;
  logic [4:0]        log_e;
  logic [DATA_W:0]   msq;
  logic [LOG_W-1:0]  lr_new;
  logic [LOG_W:0]    ld, ld_n;
  logic [LOG_W-1:0]  lnm;
  logic [LOG_W+1:0]  lnm_x, lnm_n;
  logic [64:0]       fsum_add;
  logic [63:0]       fsum_new;
  logic [63:0]       sq64;
  logic [SUM_W-2:0]  kl_full;
  logic [DATA_W-1:0] kl_v;
  logic              alert_v;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // field decode
  assign in_op     = in_tuser;
  assign in_idx    = in_tdata[DIM_AW-1:0];
  assign in_val    = in_tdata[DIM_AW+DATA_W-1:DIM_AW];
  assign in_bvar   = in_tdata[DIM_AW+2*DATA_W-1:DIM_AW+DATA_W];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_tvalid_r || out_tready;

  // effective dimension count
  always_comb begin
    if (dim_in_use_r == '0) begin
      dim = DIM_CW'(1);
    end else if (dim_in_use_r > DIM_CW'(MAX_DIM)) begin
      dim = DIM_CW'(MAX_DIM);
    end else begin
      dim = dim_in_use_r;
    end
  end
  assign idx_ok   = {1'b0, in_idx} < dim;
  assign last_dim = ({1'b0, d_r} + DIM_CW'(1)) == dim;

  // memory access control
  assign mem_ra  = (state_r == S_IDLE) ? in_idx : d_r;
  assign run_re  = (accept && in_op == OP_SAMPLE && idx_ok) || (state_r == S_QRD);
  assign run_we  = (state_r == S_SMUL);
  assign base_re = (state_r == S_QRD);
  assign base_we = accept && in_op == OP_LOAD;

  always_ff @(posedge clk) begin
    if (run_we) run_mem[idx_r] <= {m2_new, nm_r};
    if (run_re) run_q <= run_mem[mem_ra];
    if (base_we) base_mem[in_idx] <= {in_bvar, in_val};
    if (base_re) base_q <= base_mem[d_r];
  end

  // read data, an entry never written since clear reads as zero
  assign rm = run_vld_q ? run_q[DATA_W-1:0] : '0;
  assign m2 = run_vld_q ? run_q[M2_W+DATA_W-1:DATA_W] : '0;
  assign bm = base_q[DATA_W-1:0];
  assign bv = base_q[2*DATA_W-1:DATA_W];
  assign v0 = (bv == '0) ? DATA_W'(1) : bv;
  assign v1 = (var_r == '0) ? DATA_W'(1) : var_r;

  // welford update terms
  assign vc_n      = (vc_r != '1) ? vc_r + DATA_W'(1) : vc_r;
  assign s_delta   = {x_r[DATA_W-1], x_r} - {rm[DATA_W-1], rm};
  assign s_delta_n = -s_delta;
  assign s_dmag    = s_delta[DATA_W] ? s_delta_n[DATA_W-1:0] : s_delta[DATA_W-1:0];
  assign q32       = div_rsp.quo[DATA_W-1:0];
  assign nm_c      = dneg_r ? rm - q32 : rm + q32;
  assign e_diff    = {x_r[DATA_W-1], x_r} - {nm_r[DATA_W-1], nm_r};
  assign e_diff_n  = -e_diff;
  assign emag      = e_diff[DATA_W] ? e_diff_n[DATA_W-1:0] : e_diff[DATA_W-1:0];
  assign m2_sum    = {1'b0, m2} + {1'b0, mul_p[63:FRAC_BITS]};
  assign m2_new    = m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];

  // drift terms
  assign dm_diff   = {bm[DATA_W-1], bm} - {rm[DATA_W-1], rm};
  assign dm_diff_n = -dm_diff;
  assign dm        = dm_diff[DATA_W] ? dm_diff_n[DATA_W-1:0] : dm_diff[DATA_W-1:0];
  assign fd_diff   = {1'b0, var_r} - {1'b0, bv};
  assign fd_diff_n = -fd_diff;
  assign fd        = fd_diff[DATA_W] ? fd_diff_n[DATA_W-1:0] : fd_diff[DATA_W-1:0];
  assign fsum_add  = {1'b0, fsum_r} + {1'b0, mul_p};
  assign fsum_new  = fsum_add[64] ? '1 : fsum_add[63:0];
  assign sq64      = div_rsp.quo[DIV_W-1:FRAC_BITS];

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SMUL: begin
        mul_a = dmag_r;
        mul_b = emag;
      end
      S_QPRE: begin
        mul_a = dm;
        mul_b = dm;
      end
      S_LOGS: begin
        mul_a = lm_r;
        mul_b = lm_r;
      end
      S_QLN: begin
        mul_a = DATA_W'(ld_n[LOG_W:0]);
        mul_b = LN2_Q30;
        if (!ld[LOG_W]) mul_a = DATA_W'(ld);
      end
      S_QFD: begin
        mul_a = fd;
        mul_b = fd;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // integer square root step
  assign sq_t      = sqres_r + sqbit_r;
  assign sq_ge     = sqx_r >= sq_t;
  assign sqx_new   = sq_ge ? sqx_r - sq_t : sqx_r;
  assign sqres_new = sq_ge ? (sqres_r >> 1) + sqbit_r : sqres_r >> 1;

  // log2 by repeated squaring of the mantissa
  assign log_x  = lsel_r ? v1 : v0;
  assign log_e  = lead_one(log_x);
  assign msq    = mul_p[63:DATA_W-1];
  assign lr_new = lr_r | (LOG_W'(msq[DATA_W]) << lk_r);
  assign ld     = {1'b0, l0_r} - {1'b0, lr_r};
  assign ld_n   = -ld;
  assign lnm    = mul_p[LOG_W+29:30];
  assign lnm_x  = {2'b00, lnm};
  assign lnm_n  = -lnm_x;

  // final kl and alert
  assign kl_full = (!ksum_r[SUM_W-1] && ksum_r != '0) ? ksum_r[SUM_W-1:1] : '0;
  assign kl_v    = (kl_full[SUM_W-2:DATA_W] != '0) ? '1 : kl_full[DATA_W-1:0];
  assign alert_v = kl_v > kl_limit_r;

  // divider requests
  always_comb begin
    div_req = '0;
    unique case (state_r)
      S_SRD: begin
        div_req.start    = 1'b1;
        div_req.steps    = DIV_SW'(DATA_W);
        div_req.dividend = {s_dmag, {(DIV_W-DATA_W){1'b0}}};
        div_req.divisor  = vc_n;
      end
      S_QVAR: begin
        div_req.start    = (vc_r >= DATA_W'(2));
        div_req.steps    = DIV_SW'(M2_W);
        div_req.dividend = {m2, {(DIV_W-M2_W){1'b0}}};
        div_req.divisor  = vc_r - DATA_W'(1);
      end
      S_QPRE: begin
        div_req.start    = en_r;
        div_req.steps    = DIV_SW'(DATA_W + FRAC_BITS);
        div_req.dividend = {v1, {(DIV_W-DATA_W){1'b0}}};
        div_req.divisor  = v0;
      end
      S_QRAT: begin
        div_req.start    = div_rsp.done;
        div_req.steps    = DIV_SW'(DIV_W);
        div_req.dividend = {d2_r, {FRAC_BITS{1'b0}}};
        div_req.divisor  = v0;
      end
      default: div_req = '0;
    endcase
  end

  edm_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_SAMPLE && idx_ok) state_nxt = S_SRD;
        else if (accept && in_op == OP_QUERY) state_nxt = S_QRD;
      end
      S_SRD:   state_nxt = S_SDIV;
      S_SDIV:  if (div_rsp.done) state_nxt = S_SMUL;
      S_SMUL:  state_nxt = S_IDLE;
      S_QRD:   state_nxt = S_QVAR;
      S_QVAR:  state_nxt = (vc_r >= DATA_W'(2)) ? S_QVDIV : S_QPRE;
      S_QVDIV: if (div_rsp.done) state_nxt = S_QPRE;
      S_QPRE:  state_nxt = en_r ? S_QRAT : S_QEMIT;
      S_QRAT:  if (div_rsp.done) state_nxt = S_QSQ;
      S_QSQ: begin
        if (div_rsp.done) begin
          state_nxt = (div_rsp.quo[DIV_W-1:64] != '0) ? S_LOGI : S_QSQRT;
        end
      end
      S_QSQRT: if (sqbit_r == 64'd1) state_nxt = S_LOGI;
      S_LOGI:  state_nxt = S_LOGS;
      S_LOGS:  if (lk_r == '0) state_nxt = lsel_r ? S_QLN : S_LOGI;
      S_QLN:   state_nxt = S_QFD;
      S_QFD:   state_nxt = last_dim ? S_FSQRT : S_QEMIT;
      S_FSQRT: if (sqbit_r == 64'd1) state_nxt = S_QEMIT;
      S_QEMIT: if (slot_free) state_nxt = last_dim ? S_IDLE : S_QRD;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dim_in_use_r <= DIM_CW'(MAX_DIM);
      kl_limit_r   <= DATA_W'(32768);
      vc_r         <= '0;
      base_valid_r <= 1'b0;
      run_vld_r    <= '0;
      run_vld_q    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DIM: dim_in_use_r <= cfg_data[DIM_CW-1:0];
          CFG_KL:  kl_limit_r <= cfg_data;
          default: kl_limit_r <= kl_limit_r;
        endcase
      end
      // vector commit, clear and baseline valid
      if (accept && in_op == OP_SAMPLE && !idx_ok && in_tlast) vc_r <= vc_n;
      if (state_r == S_SMUL && last_r) vc_r <= vc_n;
      if (accept && in_op == OP_CLEAR) vc_r <= '0;
      if (base_we && in_tlast) base_valid_r <= 1'b1;
      // entry valid bits
      if (accept && in_op == OP_CLEAR) run_vld_r <= '0;
      else if (run_we) run_vld_r[idx_r] <= 1'b1;
      if (run_re) run_vld_q <= run_vld_r[mem_ra];
      // output register
      if (state_r == S_QEMIT && slot_free) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        x_r    <= in_val;
        idx_r  <= in_idx;
        last_r <= in_tlast;
        d_r    <= '0;
        en_r   <= base_valid_r && (vc_r > DATA_W'(10));
        ksum_r   <= '0;
        fsum_r   <= '0;
        mshift_r <= '0;
        frob_r   <= '0;
      end
      S_SRD: begin
        dmag_r <= s_dmag;
        dneg_r <= s_delta[DATA_W];
      end
      S_SDIV:  if (div_rsp.done) nm_r <= nm_c;
      S_QVAR:  var_r <= '0;
      S_QVDIV: begin
        if (div_rsp.done) begin
          var_r <= (div_rsp.quo[M2_W-1:DATA_W] != '0) ? '1 : div_rsp.quo[DATA_W-1:0];
        end
      end
      S_QPRE:  d2_r <= mul_p;
      S_QRAT: begin
        if (div_rsp.done) begin
          ratio_r <= (div_rsp.quo[M2_W-1:0] > M2_W'(TERM_CAP)) ?
                     TERM_CAP : div_rsp.quo[CAP_W-1:0];
        end
      end
      S_QSQ: begin
        if (div_rsp.done) begin
          sqt_r   <= (sq64 > 64'(TERM_CAP)) ? TERM_CAP : sq64[CAP_W-1:0];
          lsel_r  <= 1'b0;
          sqx_r   <= div_rsp.quo[63:0];
          sqres_r <= '0;
          sqbit_r <= SQ_TOP;
          if (div_rsp.quo[DIV_W-1:64] != '0) mshift_r <= '1;
        end
      end
      S_QSQRT: begin
        sqx_r   <= sqx_new;
        sqres_r <= sqres_new;
        sqbit_r <= sqbit_r >> 2;
        if (sqbit_r == 64'd1 && sqres_new[DATA_W-1:0] > mshift_r) begin
          mshift_r <= sqres_new[DATA_W-1:0];
        end
      end
      S_LOGI: begin
        lm_r <= log_x << (5'd31 - log_e);
        lr_r <= {log_e, {FRAC_BITS{1'b0}}};
        lk_r <= 4'(FRAC_BITS - 1);
      end
      S_LOGS: begin
        lm_r <= msq[DATA_W] ? msq[DATA_W:1] : msq[DATA_W-1:0];
        lr_r <= lr_new;
        lk_r <= lk_r - 4'd1;
        if (lk_r == '0 && !lsel_r) begin
          l0_r   <= lr_new;
          lsel_r <= 1'b1;
        end
      end
      S_QLN:   ln_r <= ld[LOG_W] ? lnm_n : lnm_x;
      S_QFD: begin
        fsum_r  <= fsum_new;
        ksum_r  <= ksum_r + {{(SUM_W-LOG_W-2){ln_r[LOG_W+1]}}, ln_r}
                   + SUM_W'(ratio_r) + SUM_W'(sqt_r) - ONE_Q;
        sqx_r   <= fsum_new;
        sqres_r <= '0;
        sqbit_r <= SQ_TOP;
      end
      S_FSQRT: begin
        sqx_r   <= sqx_new;
        sqres_r <= sqres_new;
        sqbit_r <= sqbit_r >> 2;
        if (sqbit_r == 64'd1) frob_r <= sqres_new[DATA_W-1:0];
      end
      S_QEMIT: begin
        if (slot_free) begin
          d_r <= d_r + DIM_AW'(1);
          out_tlast_r <= last_dim;
          if (last_dim && en_r) begin
            out_tdata_r <= {1'b0, alert_v, mshift_r, frob_r, kl_v, vc_r, var_r, rm, d_r};
          end else begin
            out_tdata_r <= {1'b0, 1'b0, {(3*DATA_W){1'b0}}, vc_r, var_r, rm, d_r};
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

>>> rtl/edm_div.sv
// shift-subtract unsigned divider, one quotient bit per cycle
module edm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  edm_pkg::div_req_t req,
  output edm_pkg::div_rsp_t rsp
);
  import edm_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_SW-1:0] cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] dvs_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  // trial subtract of the next dividend bit
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= req.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - DIV_SW'(1);
      if (cnt_r == DIV_SW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath, dividend comes in left aligned
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

>>> rtl/edm_chk.sv
// port-level checks for the drift monitor, bound to the top level
module edm_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [edm_pkg::IN_W-1:0]   in_tdata,
  input logic [1:0]                 in_tuser,
  input logic                       in_tlast,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [edm_pkg::OUT_W-1:0]  out_tdata,
  input logic                       out_tlast,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic                       cfg_index,
  input logic [edm_pkg::DATA_W-1:0] cfg_data
);
  import edm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a query request leaves the block busy in the cycle after it is accepted
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_QUERY |=> !in_tready)
    else $error("request accepted right after a query");

  // drift fields appear on the final item only
  a_drift_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[198:102] == '0)
    else $error("drift fields on a non-final item");

  // an alert needs a nonzero divergence
  a_alert_kl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[198] |-> out_tdata[133:102] != '0)
    else $error("alert with zero divergence");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind embedding_drift_monitor_unit edm_chk u_edm_chk (.*);

>>> test/embedding_drift_monitor_unit_tb.sv
// self-checking testbench for the embedding drift monitor unit
`timescale 1ns / 100ps

module embedding_drift_monitor_unit_tb;
  import edm_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [63:0] KL_CAP = 64'd1 << 40;

  typedef struct {
    logic [1:0]         op;
    logic [5:0]         idx;
    logic signed [31:0] val;
    logic [31:0]        bvar;
    logic               last;
  } elem_t;

  typedef struct {
    logic [5:0]  dim;
    logic [31:0] mean;
    logic [31:0] var_s;
    logic [31:0] cnt;
    logic [31:0] kl;
    logic [31:0] frob;
    logic [31:0] mshift;
    logic        alert;
    logic        fin;
  } stat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = OP_SAMPLE;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_DIM;
  logic [DATA_W-1:0] cfg_data = '0;

  embedding_drift_monitor_unit DUT (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] run_avg [MAX_DIM];
  logic [47:0]        run_m2 [MAX_DIM];
  logic [31:0]        vec_n;
  logic signed [31:0] ref_mu [MAX_DIM];
  logic [31:0]        ref_var [MAX_DIM];
  logic               ref_ok;
  logic [6:0]         dim_reg;
  logic [31:0]        kl_reg;

  elem_t pending_elems[$];
  stat_t expected_stats[$];
  int    mismatches = 0;
  logic  hold_go = 1'b0;
  logic signed [31:0] mu_seed [MAX_DIM];
  int    vars_seed [MAX_DIM];

  function automatic logic [63:0] mag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x = x - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // log2 in Q.16 by repeated squaring of the normalized mantissa
  function automatic logic [63:0] log2_fix(logic [31:0] x);
    int e;
    logic [63:0] m, r;
    if (x == 0) x = 1;
    e = 31;
    while (x[e] == 1'b0) e--;
    m = 64'(x) << (31 - e);
    r = 64'(e) << FRAC_BITS;
    for (int i = FRAC_BITS - 1; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] sample_variance(int d);
    logic [63:0] q;
    if (vec_n < 2) return 0;
    q = 64'(run_m2[d]) / (64'(vec_n) - 1);
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic int dims_active();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAX_DIM) return MAX_DIM;
    return int'(dim_reg);
  endfunction

  // welford update / baseline load / clear / query on one accepted request
  function automatic void model_request(elem_t it);
    int dim;
    longint x, delta, nm, sum, ld, lm;
    logic [63:0] n, q, inc, fsum, kl, frob, msh, dm, d2, ratio, sq, fd, f2, r, s;
    logic [31:0] vs, v0, v1;
    logic alert;
    stat_t st;
    dim = dims_active();
    x = longint'(it.val);
    case (it.op)
      OP_SAMPLE: begin
        if (it.idx < dim) begin
          n = (vec_n < 32'hFFFF_FFFF) ? 64'(vec_n) + 1 : 64'hFFFF_FFFF;
          delta = x - longint'(run_avg[it.idx]);
          q = mag(delta) / n;
          nm = longint'(run_avg[it.idx]) + ((delta < 0) ? -longint'(q) : longint'(q));
          inc = (mag(delta) * mag(x - nm)) >> FRAC_BITS;
          run_avg[it.idx] = nm[31:0];
          if (inc > 64'hFFFF_FFFF_FFFF - 64'(run_m2[it.idx])) run_m2[it.idx] = '1;
          else run_m2[it.idx] = run_m2[it.idx] + inc[47:0];
        end
        if (it.last && vec_n != 32'hFFFF_FFFF) vec_n++;
      end
      OP_LOAD: begin
        ref_mu[it.idx] = it.val;
        ref_var[it.idx] = it.bvar;
        if (it.last) ref_ok = 1'b1;
      end
      OP_CLEAR: begin
        for (int d = 0; d < MAX_DIM; d++) begin
          run_avg[d] = 0;
          run_m2[d] = 0;
        end
        vec_n = 0;
      end
      default: begin
        kl = 0; frob = 0; msh = 0; alert = 1'b0;
        if (ref_ok && vec_n > 10) begin
          sum = 0;
          fsum = 0;
          for (int d = 0; d < dim; d++) begin
            vs = sample_variance(d);
            v0 = (ref_var[d] != 0) ? ref_var[d] : 32'd1;
            v1 = (vs != 0) ? vs : 32'd1;
            dm = mag(longint'(ref_mu[d]) - longint'(run_avg[d]));
            d2 = dm * dm;
            ratio = {v1, 16'b0} / 64'(v0);
            sq = d2 / 64'(v0);
            if (ratio > KL_CAP) ratio = KL_CAP;
            if (sq > KL_CAP) sq = KL_CAP;
            ld = longint'(log2_fix(v0)) - longint'(log2_fix(v1));
            lm = longint'((mag(ld) * LN2_Q30) >> 30);
            sum += ((ld < 0) ? -lm : lm) + longint'(ratio) + longint'(sq)
                   - longint'(64'd1 << FRAC_BITS);
            fd = mag(longint'({1'b0, vs}) - longint'({1'b0, ref_var[d]}));
            f2 = fd * fd;
            fsum = (f2 > ~fsum) ? '1 : fsum + f2;
            q = d2 / 64'(v0);
            r = d2 % 64'(v0);
            if (q >= (64'd1 << (64 - FRAC_BITS))) s = 64'hFFFF_FFFF;
            else begin
              s = root64((q << FRAC_BITS) + ((r << FRAC_BITS) / 64'(v0)));
              if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
            end
            if (s > msh) msh = s;
          end
          kl = (sum > 0) ? 64'(sum) >> 1 : 0;
          if (kl > 64'hFFFF_FFFF) kl = 64'hFFFF_FFFF;
          frob = root64(fsum);
          if (frob > 64'hFFFF_FFFF) frob = 64'hFFFF_FFFF;
          alert = kl > 64'(kl_reg);
        end
        for (int d = 0; d < dim; d++) begin
          st.dim = d[5:0];
          st.mean = run_avg[d];
          st.var_s = sample_variance(d);
          st.cnt = vec_n;
          st.fin = (d + 1 == dim);
          st.kl = st.fin ? kl[31:0] : '0;
          st.frob = st.fin ? frob[31:0] : '0;
          st.mshift = st.fin ? msh[31:0] : '0;
          st.alert = st.fin ? alert : 1'b0;
          expected_stats.push_back(st);
        end
      end
    endcase
  endfunction

  // request driver
  int  send_gap = 0;
  bit  send_burst = 0;
  always @(posedge clk) begin
    elem_t it;
    logic nv;
    nv = in_tvalid;
    if (rst_n && !(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        model_request(pending_elems.pop_front());
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 14);
      end
      nv = 1'b0;
      if (send_gap > 0) send_gap--;
      else if (pending_elems.size() > 0) begin
        it = pending_elems[0];
        in_tdata <= {2'b00, it.bvar, it.val, it.idx};
        in_tuser <= it.op;
        in_tlast <= it.last;
        nv = 1'b1;
      end
    end
    in_tvalid <= nv;
  end

  // result monitor with random back-pressure and one long hold-off
  int  recv_stall = 0;
  int  hold_cnt = 0;
  bit  hold_done = 0;
  bit  recv_burst = 0;
  always @(posedge clk) begin
    stat_t e;
    logic [5:0] a_dim;
    logic [31:0] a_mean, a_var, a_cnt, a_kl, a_frob, a_msh;
    logic a_alert;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        {a_alert, a_msh, a_frob, a_kl, a_cnt, a_var, a_mean, a_dim} = out_tdata[198:0];
        if (expected_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result dim %0d", a_dim);
        end else begin
          e = expected_stats.pop_front();
          if (a_dim !== e.dim || a_mean !== e.mean || a_var !== e.var_s ||
              a_cnt !== e.cnt || a_kl !== e.kl || a_frob !== e.frob ||
              a_msh !== e.mshift || a_alert !== e.alert || out_tlast !== e.fin) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp dim %0d mean %h var %h cnt %0d kl %h frob %h msh %h al %b fin %b\n  got dim %0d mean %h var %h cnt %0d kl %h frob %h msh %h al %b fin %b",
                       e.dim, e.mean, e.var_s, e.cnt, e.kl, e.frob, e.mshift, e.alert,
                       e.fin, a_dim, a_mean, a_var, a_cnt, a_kl, a_frob, a_msh,
                       a_alert, out_tlast);
          end
        end
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 14);
      end
      if (hold_go && !hold_done) begin
        hold_done = 1;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** embedding_drift_monitor_unit: FAILED **");
        $finish;
      end
    end
  end

  task automatic add_elem(logic [1:0] op, int idx, logic [31:0] val, logic [31:0] bv,
                          logic last);
    elem_t it;
    it.op = op;
    it.idx = idx[5:0];
    it.val = val;
    it.bvar = bv;
    it.last = last;
    pending_elems.push_back(it);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DIM) dim_reg = data[6:0];
    else kl_reg = data;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_elems.size() > 0 || in_tvalid || expected_stats.size() > 0);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] element_value(int d);
    if ($urandom_range(0, 19) == 0) return $urandom;
    return mu_seed[d] + $urandom_range(0, vars_seed[d]) - vars_seed[d] / 2;
  endfunction

  // well-formed vectors with queries, plus some noise requests
  task automatic random_phase(int nvec, bit sparse);
    int dim, k;
    dim = dims_active();
    for (int v = 0; v < nvec; v++) begin
      if ($urandom_range(0, 7) == 0) begin
        k = $urandom_range(0, 3);
        if (k == 0)
          add_elem(OP_LOAD, $urandom_range(0, 63), mu_seed[0] + $urandom_range(0, 4096),
                   $urandom_range(1, 1 << 20), $urandom_range(0, 1));
        else if (k == 1 && dim < MAX_DIM)
          add_elem(OP_SAMPLE, $urandom_range(dim, 63), $urandom, 0, $urandom_range(0, 1));
        else if (k == 2) add_elem(OP_QUERY, 0, 0, 0, 0);
        else if (v < 2) add_elem(OP_CLEAR, 0, 0, 0, 0);
      end
      if (sparse) begin
        repeat (2) begin
          k = $urandom_range(0, dim - 1);
          add_elem(OP_SAMPLE, k, element_value(k), $urandom, 1'b0);
        end
        k = $urandom_range(0, dim - 1);
        add_elem(OP_SAMPLE, k, element_value(k), $urandom, 1'b1);
      end else begin
        for (int d = 0; d < dim; d++)
          add_elem(OP_SAMPLE, d, element_value(d), $urandom, d == dim - 1);
      end
      if (v % 7 == 6) add_elem(OP_QUERY, 0, 0, $urandom, $urandom_range(0, 1));
    end
    add_elem(OP_QUERY, 0, 0, 0, 0);
  endtask

  // stimulus sequence
  initial begin
    for (int d = 0; d < MAX_DIM; d++) begin
      run_avg[d] = 0;
      run_m2[d] = 0;
      ref_mu[d] = 0;
      ref_var[d] = 0;
      mu_seed[d] = $urandom_range(0, 1 << 19) - (1 << 18);
      vars_seed[d] = $urandom_range(1 << 12, 1 << 18);
    end
    vec_n = 0;
    ref_ok = 1'b0;
    dim_reg = 7'd64;
    kl_reg = 32'd32768;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty query, extreme elements, clear, then baseline fill
    add_elem(OP_QUERY, 0, 0, 0, 0);
    add_elem(OP_SAMPLE, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_elem(OP_SAMPLE, 63, 32'h8000_0000, 32'h0, 1'b1);
    add_elem(OP_SAMPLE, 0, 32'h8000_0000, 32'h0, 1'b0);
    add_elem(OP_SAMPLE, 63, 32'h7FFF_FFFF, 32'h0, 1'b1);
    add_elem(OP_SAMPLE, 5, 32'h0, 32'h0, 1'b1);
    add_elem(OP_QUERY, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_elem(OP_CLEAR, 0, 0, 0, 0);
    add_elem(OP_QUERY, 0, 0, 0, 0);
    for (int d = 0; d < MAX_DIM; d++) begin
      if (d == 1)
        add_elem(OP_LOAD, d, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      else if (d == 2)
        add_elem(OP_LOAD, d, 32'h7FFF_FFFF, 32'h0, 1'b0);
      else
        add_elem(OP_LOAD, d, mu_seed[d], vars_seed[d] / 3, d == MAX_DIM - 1);
    end
    drain();

    write_reg(CFG_DIM, 32'd1);
    write_reg(CFG_KL, 32'd0);
    random_phase(16, 0);
    drain();

    write_reg(CFG_DIM, 32'd0);
    write_reg(CFG_KL, $urandom);
    random_phase(14, 0);
    drain();

    // long output hold-off while requests keep coming
    write_reg(CFG_DIM, 32'd4);
    write_reg(CFG_KL, 32'hFFFF_FFFF);
    @(negedge clk);
    hold_go = 1'b1;
    random_phase(14, 0);
    drain();

    write_reg(CFG_DIM, 32'd7);
    write_reg(CFG_KL, $urandom_range(0, 1 << 18));
    add_elem(OP_LOAD, 40, 32'h1234_5678, 32'hA5A5_5A5A, 1'b1);
    random_phase(13, 1);
    drain();

    write_reg(CFG_DIM, 32'd100);
    random_phase(12, 1);
    drain();

    write_reg(CFG_DIM, 32'd64);
    write_reg(CFG_KL, 32'd32768);
    random_phase(6, 1);
    drain();

    if (mismatches == 0) $display("** embedding_drift_monitor_unit: PASSED **");
    else $display("** embedding_drift_monitor_unit: FAILED **");
    $finish;
  end

endmodule
